// ===== sv/dntd_pkg.sv =====
// ----------------------------------------------------------------------------
// dntd_pkg: shared types and tables for the day number to date converter
// Step tables for the year search, month lengths, and the control and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dntd_pkg;

    localparam int DAY_W   = 22;
    localparam int DOM_W   = 5;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 14;
    localparam int NSTEPS  = 14;
    localparam int STEP_W  = 4;
    localparam int MLEN_W  = 5;

    localparam logic [STEP_W-1:0] LAST_STEP   = STEP_W'(NSTEPS - 1);
    localparam logic [MON_W-1:0]  LAST_MONTH  = MON_W'(12);
    localparam logic [MON_W-1:0]  FEB         = MON_W'(2);
    localparam logic [MLEN_W-1:0] FEB_LEAP    = MLEN_W'(29);

    // taken-bit positions used by the leap test
    localparam int TK_C200 = 5;
    localparam int TK_C100 = 6;
    localparam int TK_F16  = 7;
    localparam int TK_F8   = 8;
    localparam int TK_F4   = 9;
    localparam int TK_F2   = 10;
    localparam int TK_F1   = 11;
    localparam int TK_Y2   = 12;
    localparam int TK_Y1   = 13;

    typedef struct packed {
        logic                load;
        logic                ystep;
        logic [STEP_W-1:0]   idx;
        logic                mstep;
        logic                out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic month_done;
    } t_dp_sts;

    // day span of each binary year-search step
    function automatic logic [DAY_W-1:0] step_days(input logic [STEP_W-1:0] idx);
        logic [DAY_W-1:0] d;
        case (idx)
            4'd0:    d = DAY_W'(2337552);
            4'd1:    d = DAY_W'(1168776);
            4'd2:    d = DAY_W'(584388);
            4'd3:    d = DAY_W'(292194);
            4'd4:    d = DAY_W'(146097);
            4'd5:    d = DAY_W'(73048);
            4'd6:    d = DAY_W'(36524);
            4'd7:    d = DAY_W'(23376);
            4'd8:    d = DAY_W'(11688);
            4'd9:    d = DAY_W'(5844);
            4'd10:   d = DAY_W'(2922);
            4'd11:   d = DAY_W'(1461);
            4'd12:   d = DAY_W'(730);
            4'd13:   d = DAY_W'(365);
            default: d = '1;
        endcase
        return d;
    endfunction

    function automatic logic [YEAR_W-1:0] step_years(input logic [STEP_W-1:0] idx);
        logic [YEAR_W-1:0] y;
        case (idx)
            4'd0:    y = YEAR_W'(6400);
            4'd1:    y = YEAR_W'(3200);
            4'd2:    y = YEAR_W'(1600);
            4'd3:    y = YEAR_W'(800);
            4'd4:    y = YEAR_W'(400);
            4'd5:    y = YEAR_W'(200);
            4'd6:    y = YEAR_W'(100);
            4'd7:    y = YEAR_W'(64);
            4'd8:    y = YEAR_W'(32);
            4'd9:    y = YEAR_W'(16);
            4'd10:   y = YEAR_W'(8);
            4'd11:   y = YEAR_W'(4);
            4'd12:   y = YEAR_W'(2);
            4'd13:   y = YEAR_W'(1);
            default: y = '0;
        endcase
        return y;
    endfunction

    function automatic logic [MLEN_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                    input logic leap);
        logic [MLEN_W-1:0] l;
        case (m)
            FEB:                       l = leap ? FEB_LEAP : MLEN_W'(28);
            4'd4, 4'd6, 4'd9, 4'd11:   l = MLEN_W'(30);
            default:                   l = MLEN_W'(31);
        endcase
        return l;
    endfunction

endpackage

// ===== sv/day_number_to_date.sv =====
// ----------------------------------------------------------------------------
// day_number_to_date: proleptic Gregorian day number to civil date
// Day 1 is 1 January of year 1; a day number of zero is flagged and gives
// 1/1/1.
//
//   channel   handshake                 payload
//   input     i_in_valid / o_in_ready   i_day_number
//   output    o_out_valid / i_out_ready o_day_of_month, o_month_number,
//                                       o_year_number, o_bad_input
//
// One beat takes a load step, a binary year search through the year compare-subtract
// unit, and a month walk that stops at month 12 at the latest.
// One item in flight; the next beat is taken once the result sits in the
// output register, which holds it while the output stalls.
// Reset is synchronous, active low, and clears control state only.
// ----------------------------------------------------------------------------
module day_number_to_date (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dntd_pkg::DAY_W-1:0]    i_day_number,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dntd_pkg::DOM_W-1:0]    o_day_of_month,
    output logic [dntd_pkg::MON_W-1:0]    o_month_number,
    output logic [dntd_pkg::YEAR_W-1:0]   o_year_number,
    output logic                          o_bad_input
);
    import dntd_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    dntd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dntd_dp u_dp (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_day_number   (i_day_number),
        .o_day_of_month (o_day_of_month),
        .o_month_number (o_month_number),
        .o_year_number  (o_year_number),
        .o_bad_input    (o_bad_input)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a conversion is running");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_month_number != '0) && (o_month_number <= LAST_MONTH)
                        && (o_day_of_month != '0) && (o_year_number != '0))
        else $error("result date out of range");

    a_bad_gives_first_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_input) |-> (o_year_number == YEAR_W'(1))
            && (o_month_number == MON_W'(1)) && (o_day_of_month == DOM_W'(1)))
        else $error("zero day number did not give 1/1/1");

endmodule

// ===== sv/dntd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dntd_ctrl: conversion sequencer
// Walks the year search steps, then the month walk, and owns both handshakes.
// ----------------------------------------------------------------------------
module dntd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  dntd_pkg::t_dp_sts i_sts,
    output dntd_pkg::t_dp_cmd o_cmd
);
    import dntd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_YEAR,
        S_MONTH,
        S_HOLD
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;
    logic                out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        o_cmd         = '0;
        o_cmd.idx     = r_step;
        n_out_valid   = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_YEAR;
                end
            end
            S_YEAR: begin
                o_cmd.ystep = 1'b1;
                n_step      = r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if (!i_sts.month_done) begin
                    o_cmd.mstep = 1'b1;
                end else if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== sv/dntd_dp.sv =====
// ----------------------------------------------------------------------------
// dntd_dp: conversion datapath
// Compare-subtract logic on the remaining days for the year search and the month
// walk, a year accumulator, the month counter and the output register.
// ----------------------------------------------------------------------------
module dntd_dp (
    input  logic                          i_clk,
    input  dntd_pkg::t_dp_cmd             i_cmd,
    output dntd_pkg::t_dp_sts             o_sts,
    input  logic [dntd_pkg::DAY_W-1:0]    i_day_number,
    output logic [dntd_pkg::DOM_W-1:0]    o_day_of_month,
    output logic [dntd_pkg::MON_W-1:0]    o_month_number,
    output logic [dntd_pkg::YEAR_W-1:0]   o_year_number,
    output logic                          o_bad_input
);
    import dntd_pkg::*;

    logic [DAY_W-1:0]  r_rem;
    logic [YEAR_W-1:0] r_year;
    logic [MON_W-1:0]  r_month;
    logic [NSTEPS-1:0] r_taken;
    logic              r_bad;

    logic [DOM_W-1:0]  r_o_day;
    logic [MON_W-1:0]  r_o_month;
    logic [YEAR_W-1:0] r_o_year;
    logic              r_o_bad;

    logic [DAY_W:0]    ydiff;
    logic              ytake;
    logic              f_is_24;
    logic              leap;
    logic [MLEN_W-1:0] mlen;
    logic              in_zero;

    assign in_zero = (i_day_number == '0);
    assign ydiff   = {1'b0, r_rem} - {1'b0, step_days(i_cmd.idx)};
    assign ytake   = !ydiff[DAY_W];

    // year - 1 = 400q + 100c + 4f + y1; leap when y1 is 3 unless a century
    // year (f is 24) that is not a multiple of 400 (c is not 3)
    assign f_is_24 = r_taken[TK_F16] && r_taken[TK_F8] && !r_taken[TK_F4]
                     && !r_taken[TK_F2] && !r_taken[TK_F1];
    assign leap    = r_taken[TK_Y2] && r_taken[TK_Y1]
                     && (!f_is_24 || (r_taken[TK_C200] && r_taken[TK_C100]));
    assign mlen    = month_len(r_month, leap);

    assign o_sts.month_done = (r_rem < DAY_W'(mlen)) || (r_month >= LAST_MONTH);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem   <= in_zero ? '0 : i_day_number - DAY_W'(1);
            r_bad   <= in_zero;
            r_year  <= YEAR_W'(1);
            r_month <= MON_W'(1);
            r_taken <= '0;
        end else if (i_cmd.ystep) begin
            if (ytake) begin
                r_rem            <= ydiff[DAY_W-1:0];
                r_year           <= r_year + step_years(i_cmd.idx);
                r_taken[i_cmd.idx] <= 1'b1;
            end
        end else if (i_cmd.mstep) begin
            r_rem   <= r_rem - DAY_W'(mlen);
            r_month <= r_month + MON_W'(1);
        end
        if (i_cmd.out_load) begin
            r_o_day   <= r_rem[DOM_W-1:0] + DOM_W'(1);
            r_o_month <= r_month;
            r_o_year  <= r_year;
            r_o_bad   <= r_bad;
        end
    end

    assign o_day_of_month = r_o_day;
    assign o_month_number = r_o_month;
    assign o_year_number  = r_o_year;
    assign o_bad_input    = r_o_bad;

endmodule
